// ===== rtl/lrb_pkg.sv =====
// Package: shared types, constants and command codes of the linear ramp bank.
package lrb_pkg;

  localparam int NUM_ELEMENTS = 16;
  localparam int IDX_W        = 4;
  localparam int LEVEL_WIDTH  = 32;
  localparam int INC_W        = LEVEL_WIDTH + 16;
  localparam int STEP_W       = 24;
  localparam int RATE_W       = 18;
  localparam int ACT_W        = 5;
  localparam int DUR_W        = 16;
  localparam int DIFF_W       = LEVEL_WIDTH + 2;
  localparam int QUO_W        = DIFF_W + 16;

  localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};
  localparam logic [RATE_W-1:0] RATE_RST = RATE_W'(48000);
  localparam logic [ACT_W-1:0]  ACT_RST  = ACT_W'(16);

  localparam logic signed [LEVEL_WIDTH-1:0] LVL_MAX = {1'b0, {(LEVEL_WIDTH-1){1'b1}}};
  localparam logic signed [LEVEL_WIDTH-1:0] LVL_MIN = {1'b1, {(LEVEL_WIDTH-1){1'b0}}};
  localparam logic signed [INC_W-1:0] INC_MAX = {1'b0, {(INC_W-1){1'b1}}};
  localparam logic signed [INC_W-1:0] INC_MIN = {1'b1, {(INC_W-1){1'b0}}};

  typedef enum logic [2:0] {
    K_TARGET = 3'd0, K_HOLD = 3'd1, K_INTERVAL = 3'd2, K_SLOPE = 3'd3,
    K_JUMP = 3'd4, K_FREEZE = 3'd5, K_TICK = 3'd6, K_ZERO = 3'd7
  } kind_t;

  localparam logic CFG_RATE = 1'b0;
  localparam logic CFG_ACT  = 1'b1;

  typedef struct packed {
    logic [STEP_W-1:0] divisor;
    logic signed [DIFF_W-1:0] dividend;
  } div_req_t;

  function automatic logic signed [LEVEL_WIDTH-1:0] sat_lvl(input logic signed [DIFF_W-1:0] v);
    if (v > DIFF_W'(LVL_MAX)) return LVL_MAX;
    if (v < DIFF_W'(LVL_MIN)) return LVL_MIN;
    return v[LEVEL_WIDTH-1:0];
  endfunction

endpackage

// ===== rtl/lrb_div.sv =====
// Sequential restoring divider: trunc(dividend * 2^16 / divisor), saturated to increment range.
module lrb_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                go,
  input  lrb_pkg::div_req_t                   req,
  output logic                                done,
  output logic signed [lrb_pkg::INC_W-1:0]    quo
);
  localparam int QW = lrb_pkg::QUO_W;
  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0] num_r, q_r;
  logic [lrb_pkg::STEP_W:0] rem_r;
  logic [lrb_pkg::STEP_W-1:0] den_r;
  logic neg_r, busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [lrb_pkg::STEP_W:0] trial;
  logic [lrb_pkg::STEP_W+1:0] sh;
  logic [QW-1:0] mag;
  logic signed [QW:0] sq;

  always_comb begin
    sh = {rem_r, num_r[QW-1]};
    trial = sh[lrb_pkg::STEP_W:0] - {1'b0, den_r};
    sq = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
    if (sq > (QW+1)'(lrb_pkg::INC_MAX)) quo = lrb_pkg::INC_MAX;
    else if (sq < (QW+1)'(lrb_pkg::INC_MIN)) quo = lrb_pkg::INC_MIN;
    else quo = sq[lrb_pkg::INC_W-1:0];
    mag = req.dividend[lrb_pkg::DIFF_W-1] ? QW'(-req.dividend) : QW'(req.dividend);
  end

  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QW);
        num_r  <= mag << 16;
        neg_r  <= req.dividend[lrb_pkg::DIFF_W-1];
        den_r  <= req.divisor;
        rem_r  <= '0;
        q_r    <= '0;
      end else if (busy_r) begin
        num_r <= num_r << 1;
        if (sh >= {1'b0, den_r}) begin
          rem_r <= trial;
          q_r   <= {q_r[QW-2:0], 1'b1};
        end else begin
          rem_r <= sh[lrb_pkg::STEP_W:0];
          q_r   <= {q_r[QW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/linear_ramp_bank_unit.sv =====
// Top level: linear ramp bank with element state in one synchronous memory.
//  channel | ports                              | handshake
//  in      | in_kind/element_index/operand/dur  | start & !busy
//  out     | out_index/level/steps_left/last    | out_valid, one cycle
//  cfg     | cfg_we/cfg_index/cfg_data          | cfg_we
// An element command steps through multiply, reciprocal scale, step count, entry read
// and decode; with a nonzero duration it then runs a 50-step divider and write-back,
// unless it is a hold whose operand or stored target is zero. One addressed past the
// active count is dropped with no busy. Tick, jump, freeze and zero sweep all 16
// entries, one read and one write each. After reset a clearing pass over all 16
// entries holds busy high. Results cannot be stalled.
module linear_ramp_bank_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [2:0]                            in_kind,
  input  logic [lrb_pkg::IDX_W-1:0]             in_element_index,
  input  logic signed [31:0]                    in_operand_value,
  input  logic [lrb_pkg::DUR_W-1:0]             in_duration_ms,
  output logic                                  out_valid,
  output logic [lrb_pkg::IDX_W-1:0]             out_index,
  output logic signed [31:0]                    out_level,
  output logic [lrb_pkg::STEP_W-1:0]            out_steps_left,
  output logic                                  out_last_of_run,
  input  logic                                  cfg_we,
  input  logic                                  cfg_index,
  input  logic [lrb_pkg::RATE_W-1:0]            cfg_data
);
  localparam int LW = lrb_pkg::LEVEL_WIDTH;
  localparam int IW = lrb_pkg::INC_W;
  localparam int DW = lrb_pkg::DIFF_W;
  localparam int NW = lrb_pkg::IDX_W;
  localparam int PW = lrb_pkg::DUR_W + lrb_pkg::RATE_W + 1;
  // floor(w / 125) = (w * RECIP_125) >> 38 for w < 2^31
  localparam logic [31:0] RECIP_125 = 32'd2199023256;
  localparam logic [31:0] W_SAT     = 32'd2097152000;

  typedef struct packed {
    logic signed [LW-1:0] cur;
    logic signed [LW-1:0] tgt;
    logic signed [IW-1:0] inc;
    logic [15:0]          frac;
  } ent_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_MUL, S_RECIP, S_STEPS, S_RD, S_CMD, S_DIV, S_SW_RD, S_SW_WR
  } state_t;

  ent_t mem [lrb_pkg::NUM_ELEMENTS];
  ent_t rd_q;
  logic [NW-1:0] rd_a;
  logic we;
  logic [NW-1:0] wa;
  ent_t wd;

  state_t st_r;
  logic [lrb_pkg::RATE_W-1:0] rate_r;
  logic [lrb_pkg::ACT_W-1:0] act_r;
  logic [lrb_pkg::STEP_W-1:0] rem_r, n_r;
  logic [2:0] kind_r;
  logic [NW-1:0] idx_r;
  logic signed [LW-1:0] x_r;
  logic [lrb_pkg::DUR_W-1:0] dur_r;
  logic [PW-1:0] prod_r;
  logic [62:0] recip_r;
  logic sat_r;
  logic [NW:0] cnt_r;
  logic mode_r;  // sweep advances (tick, rem>1)
  logic jump_r;
  logic tick_r;
  logic signed [LW-1:0] ntgt_r;

  logic div_go, div_done;
  lrb_pkg::div_req_t div_req;
  logic signed [IW-1:0] div_q;

  lrb_div u_div (.clk(clk), .rst_n(rst_n), .go(div_go), .req(div_req),
                 .done(div_done), .quo(div_q));

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[rd_a];
  end

  logic [lrb_pkg::ACT_W-1:0] act;
  assign act = (act_r > lrb_pkg::ACT_W'(lrb_pkg::NUM_ELEMENTS)) ?
               lrb_pkg::ACT_W'(lrb_pkg::NUM_ELEMENTS) : act_r;

  // step count: (prod + 500) / 1000 as ((prod + 500) >> 3) / 125
  logic [PW-1:0] rnd;
  logic [31:0] wq;
  logic [lrb_pkg::STEP_W-1:0] qv;
  logic [lrb_pkg::STEP_W-1:0] steps;
  always_comb begin
    rnd = prod_r + PW'(500);
    wq = rnd[PW-1:3];
    qv = recip_r[61:38];
    if (sat_r) steps = lrb_pkg::STEP_MAX;
    else if (qv == '0) steps = 24'd1;
    else steps = qv;
  end

  // slope product and command decode on read entry
  logic signed [LW+lrb_pkg::DUR_W:0] slp;
  logic signed [LW-1:0] iv;
  logic signed [DW-1:0] dv;
  logic signed [LW-1:0] ntgt;
  logic zero_inc, set_now;
  always_comb begin
    slp = $signed({1'b0, dur_r}) * x_r;
    iv = x_r;
    if (kind_r == lrb_pkg::K_SLOPE)
      iv = (slp > (LW+17)'(lrb_pkg::LVL_MAX)) ? lrb_pkg::LVL_MAX :
           (slp < (LW+17)'(lrb_pkg::LVL_MIN)) ? lrb_pkg::LVL_MIN :
           $signed(slp[LW-1:0]);
    dv = DW'(x_r) - DW'(rd_q.cur);
    ntgt = x_r;
    zero_inc = 1'b0;
    set_now = 1'b0;
    case (kind_r)
      lrb_pkg::K_INTERVAL, lrb_pkg::K_SLOPE: begin
        dv = DW'(iv);
        ntgt = lrb_pkg::sat_lvl(DW'(rd_q.cur) + DW'(iv));
      end
      lrb_pkg::K_HOLD: begin
        if (x_r == '0) zero_inc = 1'b1;
        else if (rd_q.tgt == '0) set_now = 1'b1;
      end
      default: ;
    endcase
  end

  // tick advance of read entry
  logic [16:0] fs;
  logic signed [DW+16:0] lev;
  logic signed [LW-1:0] alev;
  logic ahit;
  always_comb begin
    fs = {1'b0, rd_q.frac} + {1'b0, rd_q.inc[15:0]};
    lev = (DW+17)'(rd_q.cur) + (DW+17)'($signed(rd_q.inc[IW-1:16])) + (DW+17)'(fs[16]);
    ahit = (lev > (DW+17)'(lrb_pkg::LVL_MAX)) || (lev < (DW+17)'(lrb_pkg::LVL_MIN));
    alev = ahit ? (lev < 0 ? lrb_pkg::LVL_MIN : lrb_pkg::LVL_MAX) : lev[LW-1:0];
  end

  logic [NW-1:0] ci;
  assign ci = cnt_r[NW-1:0];

  always_comb begin
    we = 1'b0;
    wa = idx_r;
    wd = rd_q;
    rd_a = idx_r;
    div_go = 1'b0;
    div_req.divisor = n_r;
    div_req.dividend = dv;
    unique case (st_r)
      S_CLR: begin
        we = 1'b1; wa = ci; wd = '0;
      end
      S_SW_RD: rd_a = ci;
      S_SW_WR: begin
        we = 1'b1; wa = ci;
        if (jump_r) begin
          wd.cur = rd_q.tgt; wd.inc = '0; wd.frac = '0;
        end else if (mode_r) begin
          wd.cur = alev; wd.frac = ahit ? 16'd0 : fs[15:0];
        end else if (kind_r == lrb_pkg::K_FREEZE) begin
          wd.inc = '0; wd.tgt = rd_q.cur; wd.frac = '0;
        end else if (kind_r == lrb_pkg::K_ZERO) begin
          wd = '0;
        end
      end
      S_CMD: begin
        div_req.dividend = dv;
        if (dur_r == '0) begin
          we = (kind_r != lrb_pkg::K_SLOPE);
          wd.inc = '0; wd.frac = '0;
          wd.cur = (kind_r == lrb_pkg::K_INTERVAL) ?
                   lrb_pkg::sat_lvl(DW'(rd_q.cur) + DW'(x_r)) : x_r;
          wd.tgt = wd.cur;
        end else if (zero_inc) begin
          we = 1'b1; wd.inc = '0; wd.tgt = '0;
        end else if (set_now) begin
          we = 1'b1; wd.inc = '0; wd.frac = '0; wd.cur = x_r; wd.tgt = x_r;
        end else begin
          div_go = 1'b1;
        end
      end
      S_DIV: begin
        we = div_done; wd.inc = div_q; wd.tgt = ntgt_r;
      end
      default: ;
    endcase
  end

  assign busy = (st_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      cnt_r <= '0;
      rate_r <= lrb_pkg::RATE_RST;
      act_r <= lrb_pkg::ACT_RST;
      rem_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == lrb_pkg::CFG_RATE) rate_r <= cfg_data;
        else act_r <= cfg_data[lrb_pkg::ACT_W-1:0];
      end
      unique case (st_r)
        S_CLR: begin
          cnt_r <= cnt_r + 1'b1;
          if (ci == NW'(lrb_pkg::NUM_ELEMENTS - 1)) st_r <= S_IDLE;
        end
        S_IDLE: if (start) begin
          kind_r <= in_kind;
          idx_r <= in_element_index;
          x_r <= in_operand_value;
          dur_r <= in_duration_ms;
          cnt_r <= '0;
          jump_r <= 1'b0; mode_r <= 1'b0; tick_r <= 1'b0;
          if (in_kind <= lrb_pkg::K_SLOPE) begin
            if ((lrb_pkg::ACT_W)'(in_element_index) < act) st_r <= S_MUL;
          end else begin
            if (in_kind == lrb_pkg::K_TICK) begin
              tick_r <= 1'b1;
              mode_r <= (rem_r > 24'd1);
              jump_r <= (rem_r == 24'd1);
              if (rem_r > 24'd1) rem_r <= rem_r - 1'b1;
              else rem_r <= '0;
            end else begin
              jump_r <= (in_kind == lrb_pkg::K_JUMP);
              rem_r <= '0;
            end
            st_r <= S_SW_RD;
          end
        end
        S_MUL: begin
          prod_r <= PW'(dur_r) * PW'(rate_r);
          st_r <= S_RECIP;
        end
        S_RECIP: begin
          recip_r <= 63'(wq[30:0]) * 63'(RECIP_125);
          sat_r <= (wq >= W_SAT);
          st_r <= S_STEPS;
        end
        S_STEPS: begin
          n_r <= steps;
          rem_r <= (dur_r == '0) ? '0 : steps;
          st_r <= S_RD;
        end
        S_RD: st_r <= S_CMD;
        S_CMD: begin
          ntgt_r <= ntgt;
          st_r <= div_go ? S_DIV : S_IDLE;
        end
        S_DIV: if (div_done) st_r <= S_IDLE;
        S_SW_RD: st_r <= S_SW_WR;
        S_SW_WR: begin
          if (tick_r && ((lrb_pkg::ACT_W)'(cnt_r) < act)) begin
            out_valid <= 1'b1;
            out_index <= ci;
            out_level <= 32'(wd.cur);
            out_steps_left <= rem_r;
            out_last_of_run <= ((lrb_pkg::ACT_W)'(cnt_r) + 1'b1 == act);
          end
          cnt_r <= cnt_r + 1'b1;
          st_r <= (ci == NW'(lrb_pkg::NUM_ELEMENTS - 1)) ? S_IDLE : S_SW_RD;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/lrb_checker.sv =====
// Checker: port-level assertions for the linear ramp bank, bound to the top level.
module lrb_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic [2:0] in_kind,
  input logic out_valid,
  input logic out_last_of_run,
  input logic [3:0] out_index
);
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind > lrb_pkg::K_SLOPE) |=> busy)
    else $error("accepted word did not raise busy");
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy || out_last_of_run) else $error("result while idle");
  a_next_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_of_run) |=> !out_valid ##1 (out_valid && out_index == $past(out_index, 2) + 4'd1))
    else $error("result index out of order");
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind != lrb_pkg::K_TICK) |=> !out_valid)
    else $error("result from non-tick word");
endmodule

bind linear_ramp_bank_unit lrb_checker u_chk (.clk(clk), .rst_n(rst_n), .start(start),
  .busy(busy), .in_kind(in_kind), .out_valid(out_valid),
  .out_last_of_run(out_last_of_run), .out_index(out_index));
